### rtl/sfc_pkg.sv
// Shared types, field widths and the square-root step for the sphere cull pipeline.
// No dependencies; imported by every module of the block.
package sfc_pkg;

    localparam int COMP_W    = 21;          // Q9.12 matrix entry
    localparam int CTR_W     = 24;          // Q12.12 center / radius
    localparam int COL_W     = 3 * COMP_W;  // packed column
    localparam int NRM_W     = 14;          // Q2.12 plane normal
    localparam int OFF_W     = 22;          // Q10.12 plane offset
    localparam int PLANE_W   = 64;
    localparam int REG_COUNT = 6;           // planes held in registers
    localparam int CFG_IDX_W = 3;
    localparam int SQ_W      = 42;          // sum of three squared entries
    localparam int ROOT_W    = 21;          // floor(sqrt) of SQ_W bits
    localparam int RT_STEPS  = 3;           // root bits per pipeline stage
    localparam int RT_STAGES = ROOT_W / RT_STEPS;
    localparam int RAD_W     = CTR_W + ROOT_W;

    typedef struct packed {
        logic [SQ_W-1:0]   rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    // Resolve RT_STEPS root bits, top bit first_bit downward.
    // rem holds v - root^2; setting bit b adds (root << (b+1)) + 2^(2b).
    function automatic t_sqrt sqrt_stage(t_sqrt din, int unsigned first_bit);
        t_sqrt           d;
        logic [SQ_W+1:0] test;
        int unsigned     b;
        d = din;
        for (int k = 0; k < RT_STEPS; k++) begin
            b    = first_bit - k;
            test = ((SQ_W+2)'(d.root) << (b + 1)) | ((SQ_W+2)'(1) << (2 * b));
            if ({2'b00, d.rem} >= test) begin
                d.rem  = SQ_W'({2'b00, d.rem} - test);
                d.root = d.root | (ROOT_W'(1) << b);
            end
        end
        return d;
    endfunction

endpackage

### rtl/sfc_plane_regs.sv
// Plane configuration registers written through the config request channel.
// Depends on sfc_pkg.
module sfc_plane_regs
    import sfc_pkg::*;
#(
    parameter int N = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [PLANE_W-1:0]        i_cfg_data,
    output logic [N-1:0][PLANE_W-1:0] o_planes
);

    logic [N-1:0][PLANE_W-1:0] r_planes;

    // one register per plane; indexes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (i_cfg_valid) begin
            for (int i = 0; i < N; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_planes[i] <= i_cfg_data;
                end
            end
        end
    end

    assign o_planes = r_planes;

endmodule

### rtl/sfc_sqrt.sv
// Pipelined integer square root, RT_STEPS result bits per stage, with sideband.
// Depends on sfc_pkg.
module sfc_sqrt
    import sfc_pkg::*;
#(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_value,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    t_sqrt                   r_st   [RT_STAGES];
    logic [SIDE_W-1:0]       r_side [RT_STAGES];
    logic [RT_STAGES-1:0]    r_v;

    // stage 0 starts from the raw value and an empty root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RT_STAGES-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < RT_STAGES; s++) begin : g_stage
        t_sqrt             w_in;
        logic [SIDE_W-1:0] w_side;
        if (s == 0) begin : g_first
            assign w_in   = '{rem: i_value, root: '0};
            assign w_side = i_side;
        end else begin : g_next
            assign w_in   = r_st[s-1];
            assign w_side = r_side[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s]   <= sqrt_stage(w_in, ROOT_W - 1 - s * RT_STEPS);
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_v[RT_STAGES-1];
    assign o_root  = r_st[RT_STAGES-1].root;
    assign o_side  = r_side[RT_STAGES-1];

endmodule

### rtl/sfc_plane_test.sv
// One plane test: signed distance of the world center plus radius, two stages.
// Depends on sfc_pkg.
module sfc_plane_test
    import sfc_pkg::*;
#(
    parameter int FRAC_BITS = 12,
    parameter int WC_W      = 47
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [PLANE_W-1:0]     i_plane,
    input  logic signed [WC_W-1:0] i_wc_x,
    input  logic signed [WC_W-1:0] i_wc_y,
    input  logic signed [WC_W-1:0] i_wc_z,
    input  logic [RAD_W-1:0]       i_rad,
    output logic                   o_cull
);

    localparam int PROD_W = NRM_W + WC_W;
    localparam int DIST_W = PROD_W + 3;

    logic signed [NRM_W-1:0]  w_nx, w_ny, w_nz;
    logic signed [OFF_W-1:0]  w_off;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [OFF_W-1:0]  r_off;
    logic [RAD_W-1:0]         r_rad;
    logic [DIST_W-1:0]        w_sum;
    logic                     r_cull;

    assign w_nx  = i_plane[NRM_W-1:0];
    assign w_ny  = i_plane[2*NRM_W-1:NRM_W];
    assign w_nz  = i_plane[3*NRM_W-1:2*NRM_W];
    assign w_off = i_plane[PLANE_W-1:3*NRM_W];

    // stage A: normal times world center
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= w_nx * i_wc_x;
            r_py  <= w_ny * i_wc_y;
            r_pz  <= w_nz * i_wc_z;
            r_off <= w_off;
            r_rad <= i_rad;
        end
    end

    // stage B: culled when distance + radius < 0 (at 3F fraction bits)
    assign w_sum = DIST_W'(r_px) + DIST_W'(r_py) + DIST_W'(r_pz)
                 + (DIST_W'(r_off) << (2 * FRAC_BITS))
                 + (DIST_W'(r_rad) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cull <= w_sum[DIST_W-1];
        end
    end

    assign o_cull = r_cull;

endmodule

### rtl/sphere_frustum_cull_core.sv
// Sphere versus frustum cull.
// Throughput one request per cycle; the whole pipeline advances together and holds
// while a finished result waits. The square root takes 3 bits per stage over 7 stages.
// Synchronous active-low reset clears valid bits and all plane registers (all visible).
// Depends on sfc_pkg, sfc_plane_regs, sfc_sqrt, sfc_plane_test.
module sphere_frustum_cull_core
    import sfc_pkg::*;
#(
    parameter int FRAC_BITS   = 12,
    parameter int PLANE_COUNT = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COL_W-1:0]     i_basis_x_column,
    input  logic [COL_W-1:0]     i_basis_y_column,
    input  logic [COL_W-1:0]     i_basis_z_column,
    input  logic [COL_W-1:0]     i_translation_column,
    input  logic signed [CTR_W-1:0] i_center_x,
    input  logic signed [CTR_W-1:0] i_center_y,
    input  logic signed [CTR_W-1:0] i_center_z,
    input  logic [CTR_W-1:0]     i_local_radius,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_visible,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PLANE_W-1:0]   i_cfg_data
);

    localparam int NP     = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;
    localparam int MP_W   = COMP_W + CTR_W;
    localparam int WC_W   = ((COMP_W + FRAC_BITS > MP_W) ? COMP_W + FRAC_BITS : MP_W) + 2;
    localparam int SQE_W  = 2 * COMP_W - 1;
    localparam int SIDE_W = 3 * WC_W + CTR_W;

    logic w_en;

    // stage 0: input registers
    logic                     r_v0;
    logic [COL_W-1:0]         r_col [4];
    logic signed [CTR_W-1:0]  r_c [3];
    logic [CTR_W-1:0]         r_r0;

    // stage 1: products
    logic                     r_v1;
    logic signed [MP_W-1:0]   r_mp [3][3];
    logic signed [COMP_W-1:0] r_t [3];
    logic [SQE_W-1:0]         r_sq [3][3];
    logic [CTR_W-1:0]         r_r1;

    // stage 2: sums
    logic                     r_v2;
    logic signed [WC_W-1:0]   r_wc2 [3];
    logic [SQ_W-1:0]          r_len [3];
    logic [CTR_W-1:0]         r_r2;

    // stage 3: largest squared length
    logic                     r_v3;
    logic [SQ_W-1:0]          r_max;
    logic [SIDE_W-1:0]        r_side3;

    logic                     w_sv;
    logic [ROOT_W-1:0]        w_scale;
    logic [SIDE_W-1:0]        w_side;

    // stage 4: world radius
    logic                     r_v4;
    logic [RAD_W-1:0]         r_rad;
    logic signed [WC_W-1:0]   r_wc4 [3];

    logic                     r_v5, r_v6;
    logic [NP-1:0]            w_cull;
    logic [NP-1:0][PLANE_W-1:0] w_planes;
    logic                     r_out_v, r_out_vis;

    assign w_en        = !r_out_v || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    sfc_plane_regs #(.N(NP)) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_planes    (w_planes)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v0    <= i_valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= w_sv;
            r_v5    <= r_v4;
            r_v6    <= r_v5;
            r_out_v <= r_v6;
        end
    end

    // datapath before the square root
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col[0] <= i_basis_x_column;
            r_col[1] <= i_basis_y_column;
            r_col[2] <= i_basis_z_column;
            r_col[3] <= i_translation_column;
            r_c[0]   <= i_center_x;
            r_c[1]   <= i_center_y;
            r_c[2]   <= i_center_z;
            r_r0     <= i_local_radius;

            // r_mp[j][i]: column j component i times center j
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_mp[j][i] <= $signed(r_col[j][i*COMP_W +: COMP_W]) * r_c[j];
                    r_sq[j][i] <= SQE_W'($signed(r_col[j][i*COMP_W +: COMP_W])
                                       * $signed(r_col[j][i*COMP_W +: COMP_W]));
                end
            end
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= r_col[3][i*COMP_W +: COMP_W];
            end
            r_r1 <= r_r0;

            for (int i = 0; i < 3; i++) begin
                r_wc2[i] <= WC_W'(r_mp[0][i]) + WC_W'(r_mp[1][i]) + WC_W'(r_mp[2][i])
                          + (WC_W'(r_t[i]) <<< FRAC_BITS);
                r_len[i] <= SQ_W'(r_sq[i][0]) + SQ_W'(r_sq[i][1]) + SQ_W'(r_sq[i][2]);
            end
            r_r2 <= r_r1;

            if (r_len[0] >= r_len[1] && r_len[0] >= r_len[2]) begin
                r_max <= r_len[0];
            end else if (r_len[1] >= r_len[2]) begin
                r_max <= r_len[1];
            end else begin
                r_max <= r_len[2];
            end
            r_side3 <= {r_wc2[0], r_wc2[1], r_wc2[2], r_r2};
        end
    end

    sfc_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_value (r_max),
        .i_side  (r_side3),
        .o_valid (w_sv),
        .o_root  (w_scale),
        .o_side  (w_side)
    );

    // world radius = local radius * scale
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad    <= w_side[CTR_W-1:0] * w_scale;
            r_wc4[0] <= w_side[CTR_W+2*WC_W +: WC_W];
            r_wc4[1] <= w_side[CTR_W+WC_W +: WC_W];
            r_wc4[2] <= w_side[CTR_W +: WC_W];
        end
    end

    for (genvar p = 0; p < NP; p++) begin : g_plane
        sfc_plane_test #(.FRAC_BITS(FRAC_BITS), .WC_W(WC_W)) u_test (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_plane (w_planes[p]),
            .i_wc_x  (r_wc4[0]),
            .i_wc_y  (r_wc4[1]),
            .i_wc_z  (r_wc4[2]),
            .i_rad   (r_rad),
            .o_cull  (w_cull[p])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_vis <= ~|w_cull;
        end
    end

    assign o_valid   = r_out_v;
    assign o_visible = r_out_vis;

    // pipeline holds its stage 0, 4 and 6 valid bits while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_v0 == $past(r_v0)) && (r_v4 == $past(r_v4)) && (r_v6 == $past(r_v6)))
        else $error("pipeline moved while stalled");

    // an accepted request occupies stage 0
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v0)
        else $error("accepted request lost");

    // zeroed planes never cull
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 && (w_planes == '0) |-> (w_cull == '0))
        else $error("zero plane culled");

endmodule
